[src/sahfb_pkg.sv]
// shared types, character codes and hex helper for the ascii hex frame builder
// no dependencies
`default_nettype none

package sahfb_pkg;

    localparam logic [1:0] OP_READ  = 2'd0;
    localparam logic [1:0] OP_WR16  = 2'd1;
    localparam logic [1:0] OP_WR32  = 2'd2;
    localparam logic [1:0] OP_POINT = 2'd3;

    localparam logic [7:0] CH_SOH = 8'h01;
    localparam logic [7:0] CH_STX = 8'h02;
    localparam logic [7:0] CH_ETX = 8'h03;
    localparam logic [7:0] CH_EOT = 8'h04;

    localparam int unsigned NIBBLES    = 13;
    localparam int unsigned HDR_DIGITS = 3;

    typedef struct packed {
        logic load;
        logic shift;
    } sreg_ctrl_t;

    typedef struct packed {
        logic clear;
        logic add;
    } sum_ctrl_t;

    function automatic logic [7:0] hex_ascii(input logic [3:0] nib);
        logic [7:0] n8;
        n8 = {4'd0, nib};
        hex_ascii = (nib < 4'd10) ? (8'h30 + n8) : (8'h37 + n8);
    endfunction

endpackage

`default_nettype wire

[src/sahfb_digit_sreg.sv]
// nibble shift register holding the hex digits of one frame, top digit first
// depends on sahfb_pkg
`default_nettype none

module sahfb_digit_sreg (
    input  wire logic                            aclk,
    input  wire sahfb_pkg::sreg_ctrl_t           ctrl,
    input  wire logic [sahfb_pkg::NIBBLES*4-1:0] load_data,
    output logic [3:0]                           digit
);

    localparam int unsigned W = sahfb_pkg::NIBBLES * 4;

    logic [W-1:0] sr_reg;

    always_ff @(posedge aclk) begin
        if (ctrl.load) begin
            sr_reg <= load_data;
        end else if (ctrl.shift) begin
            sr_reg <= {sr_reg[W-5:0], 4'd0};
        end
    end

    assign digit = sr_reg[W-1:W-4];

endmodule

`default_nettype wire

[src/sahfb_cksum.sv]
// running modulo 256 byte sum for the frame checksum
// depends on sahfb_pkg
`default_nettype none

module sahfb_cksum (
    input  wire logic                  aclk,
    input  wire sahfb_pkg::sum_ctrl_t  ctrl,
    input  wire logic [7:0]            add_byte,
    output logic [7:0]                 sum
);

    logic [7:0] sum_reg;

    always_ff @(posedge aclk) begin
        if (ctrl.clear) begin
            sum_reg <= 8'd0;
        end else if (ctrl.add) begin
            sum_reg <= sum_reg + add_byte;
        end
    end

    assign sum = sum_reg;

endmodule

`default_nettype wire

[src/servo_ascii_hex_frame_builder.sv]
// top level: byte sequencer and output register of the ascii hex frame builder
// depends on sahfb_pkg, sahfb_digit_sreg, sahfb_cksum
//
// channel  dir  width  contents
// s_       in   64     request word: op, station, command_code, item_number,
//                      write_value, point_position
// m_       out  8      frame byte, tlast on the last checksum digit
//
// one frame byte leaves per cycle while m_tready is high; frames are 11, 15 or 19
// bytes long for read, 16-bit write and 32-bit or point write
// the digits leave a nibble shift register one per cycle while m_tready is high;
// the next request is taken in the cycle the last checksum digit is registered
// a stall on m_tready holds the sequencer and the output register
// aresetn clears the sequencer and the output valid
`default_nettype none

module servo_ascii_hex_frame_builder (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    // [1:0] op, [5:2] station, [13:6] command_code, [21:14] item_number,
    // [53:22] write_value, [61:54] point_position, [63:62] zero
    input  wire logic [63:0] s_tdata,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // [7:0] frame_byte
    output logic [7:0]       m_tdata,
    // frame_end
    output logic             m_tlast
);

    typedef enum logic [3:0] {
        ST_IDLE, ST_EOT, ST_SOH, ST_HDR, ST_STX, ST_BODY, ST_ETX, ST_CKHI, ST_CKLO
    } state_t;

    state_t      state_reg, state_next;
    logic [3:0]  cnt_reg, cnt_next;
    logic [1:0]  op_reg, op_next;
    logic        valid_reg, valid_next;
    logic [7:0]  data_reg, data_next;
    logic        last_reg, last_next;

    logic        adv, accept;
    logic [3:0]  digit;
    logic [7:0]  sum;
    logic [7:0]  add_byte;
    logic [3:0]  body_last;
    logic [31:0] payload;

    sahfb_pkg::sreg_ctrl_t sreg_ctrl;
    sahfb_pkg::sum_ctrl_t  sum_ctrl;

    logic [1:0]  in_op;
    logic [3:0]  in_station;
    logic [7:0]  in_cmd, in_item, in_point;
    logic [31:0] in_value;

    assign in_op      = s_tdata[1:0];
    assign in_station = s_tdata[5:2];
    assign in_cmd     = s_tdata[13:6];
    assign in_item    = s_tdata[21:14];
    assign in_value   = s_tdata[53:22];
    assign in_point   = s_tdata[61:54];

    always_comb begin
        case (in_op)
            sahfb_pkg::OP_WR16:  payload = {in_value[15:0], 16'd0};
            sahfb_pkg::OP_WR32:  payload = in_value;
            sahfb_pkg::OP_POINT: payload = {in_point, in_value[23:0]};
            default:             payload = 32'd0;
        endcase
    end

    always_comb begin
        case (op_reg)
            sahfb_pkg::OP_WR16:  body_last = 4'd5;
            sahfb_pkg::OP_WR32:  body_last = 4'd9;
            sahfb_pkg::OP_POINT: body_last = 4'd9;
            default:             body_last = 4'd1;
        endcase
    end

    assign adv      = !valid_reg || m_tready;
    assign s_tready = (state_reg == ST_IDLE) || (state_reg == ST_CKLO && adv);
    assign accept   = s_tvalid && s_tready;

    always_comb begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        op_next        = op_reg;
        valid_next     = valid_reg && !m_tready;
        data_next      = data_reg;
        last_next      = last_reg;
        sreg_ctrl      = '0;
        sum_ctrl       = '0;
        add_byte       = sahfb_pkg::hex_ascii(digit);
        if (adv) begin
            case (state_reg)
                ST_EOT: begin
                    valid_next = 1'b1;
                    data_next  = sahfb_pkg::CH_EOT;
                    last_next  = 1'b0;
                    state_next = ST_SOH;
                end
                ST_SOH: begin
                    valid_next = 1'b1;
                    data_next  = sahfb_pkg::CH_SOH;
                    last_next  = 1'b0;
                    cnt_next   = 4'(sahfb_pkg::HDR_DIGITS - 1);
                    state_next = ST_HDR;
                end
                ST_HDR, ST_BODY: begin
                    valid_next      = 1'b1;
                    data_next       = add_byte;
                    last_next       = 1'b0;
                    sreg_ctrl.shift = 1'b1;
                    sum_ctrl.add    = 1'b1;
                    if (cnt_reg == 4'd0) begin
                        state_next = (state_reg == ST_HDR) ? ST_STX : ST_ETX;
                    end else begin
                        cnt_next = cnt_reg - 4'd1;
                    end
                end
                ST_STX: begin
                    add_byte     = sahfb_pkg::CH_STX;
                    valid_next   = 1'b1;
                    data_next    = add_byte;
                    last_next    = 1'b0;
                    sum_ctrl.add = 1'b1;
                    cnt_next     = body_last;
                    state_next   = ST_BODY;
                end
                ST_ETX: begin
                    add_byte     = sahfb_pkg::CH_ETX;
                    valid_next   = 1'b1;
                    data_next    = add_byte;
                    last_next    = 1'b0;
                    sum_ctrl.add = 1'b1;
                    state_next   = ST_CKHI;
                end
                ST_CKHI: begin
                    valid_next = 1'b1;
                    data_next  = sahfb_pkg::hex_ascii(sum[7:4]);
                    last_next  = 1'b0;
                    state_next = ST_CKLO;
                end
                ST_CKLO: begin
                    valid_next = 1'b1;
                    data_next  = sahfb_pkg::hex_ascii(sum[3:0]);
                    last_next  = 1'b1;
                    state_next = ST_IDLE;
                end
                default: begin
                    state_next = state_reg;
                end
            endcase
        end
        if (accept) begin
            sreg_ctrl.load = 1'b1;
            sum_ctrl.clear = 1'b1;
            op_next        = in_op;
            state_next     = ST_EOT;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            valid_reg <= valid_next;
        end
        cnt_reg  <= cnt_next;
        op_reg   <= op_next;
        data_reg <= data_next;
        last_reg <= last_next;
    end

    sahfb_digit_sreg u_digits (
        .aclk      (aclk),
        .ctrl      (sreg_ctrl),
        .load_data ({in_station, in_cmd, in_item, payload}),
        .digit     (digit)
    );

    sahfb_cksum u_cksum (
        .aclk     (aclk),
        .ctrl     (sum_ctrl),
        .add_byte (add_byte),
        .sum      (sum)
    );

    assign m_tvalid = valid_reg;
    assign m_tdata  = data_reg;
    assign m_tlast  = last_reg;

endmodule

`default_nettype wire
